// ===== sv/pedal_override_controller_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pedal override controller
// Shared concurrent assertion forms, clocked on clk; POC_ASSERT is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PEDAL_OVERRIDE_CONTROLLER_TOP_MACROS_SVH
`define PEDAL_OVERRIDE_CONTROLLER_TOP_MACROS_SVH

// checked only out of reset
`define POC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define POC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/poc_pkg.sv =====
// ----------------------------------------------------------------------------
// poc_pkg
// Constants, types and the CRC-8 byte update shared by the controller.
// ----------------------------------------------------------------------------
package poc_pkg;

	localparam int CNT_BITS   = 4;
	localparam int FRAME_BYTES = 6;
	localparam int CRC_BYTES  = FRAME_BYTES - 1;
	localparam int CRC_MSG_W  = 8 * CRC_BYTES;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'hD5;

	localparam logic [31:0] REBOOT_KEY_LO  = 32'hdeadface;
	localparam logic [31:0] REBOOT_SOFT_HI = 32'h0ab00b1e;
	localparam logic [31:0] REBOOT_BOOT_HI = 32'h02b00b1e;

	// event codes
	localparam logic [1:0] OP_FRAME   = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_PEDAL   = 2'd2;
	localparam logic [1:0] OP_BUS_ERR = 2'd3;

	// fault codes
	localparam logic [2:0] FLT_NONE    = 3'd0;
	localparam logic [2:0] FLT_INVALID = 3'd1;
	localparam logic [2:0] FLT_BAD_CRC = 3'd2;
	localparam logic [2:0] FLT_BUS_ERR = 3'd3;
	localparam logic [2:0] FLT_SEND    = 3'd4;
	localparam logic [2:0] FLT_TIMEOUT = 3'd5;

	// reboot requests
	localparam logic [1:0] RBT_NONE = 2'd0;
	localparam logic [1:0] RBT_SOFT = 2'd1;
	localparam logic [1:0] RBT_BOOT = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_INPUT_ID  = 2'd0;
	localparam logic [1:0] CFG_OUTPUT_ID = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

	localparam logic [10:0] INPUT_ID_RST  = 11'd512;
	localparam logic [10:0] OUTPUT_ID_RST = 11'd513;
	localparam logic [15:0] TIMEOUT_RST   = 16'd10;

	typedef logic [CNT_BITS-1:0] cnt_t;

	typedef struct packed {
		logic [15:0] drive_a;
		logic [15:0] drive_b;
		logic        tx_valid;
		logic [31:0] tx_low_word;
		logic [15:0] tx_high_word;
		logic        led_on;
		logic [2:0]  fault_code;
		logic [1:0]  reboot_request;
	} result_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== sv/poc_evt_if.sv =====
// ----------------------------------------------------------------------------
// poc_evt_if
// Event channel: valid/ready handshake with one event word.
// ----------------------------------------------------------------------------
interface poc_evt_if;

	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [10:0] frame_id;
	logic [31:0] frame_low_word;
	logic [31:0] frame_high_word;
	logic        mailbox_free;
	logic [11:0] sample_a;
	logic [11:0] sample_b;

	modport source (
		output valid, operation, frame_id, frame_low_word, frame_high_word,
		       mailbox_free, sample_a, sample_b,
		input  ready
	);

	modport sink (
		input  valid, operation, frame_id, frame_low_word, frame_high_word,
		       mailbox_free, sample_a, sample_b,
		output ready
	);

endinterface

// ===== sv/poc_res_if.sv =====
// ----------------------------------------------------------------------------
// poc_res_if
// Result channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface poc_res_if;

	logic        valid;
	logic        ready;
	logic [15:0] drive_a;
	logic [15:0] drive_b;
	logic        tx_valid;
	logic [31:0] tx_low_word;
	logic [15:0] tx_high_word;
	logic        led_on;
	logic [2:0]  fault_code;
	logic [1:0]  reboot_request;

	modport source (
		output valid, drive_a, drive_b, tx_valid, tx_low_word, tx_high_word,
		       led_on, fault_code, reboot_request,
		input  ready
	);

	modport sink (
		input  valid, drive_a, drive_b, tx_valid, tx_low_word, tx_high_word,
		       led_on, fault_code, reboot_request,
		output ready
	);

endinterface

// ===== sv/poc_crc8.sv =====
// ----------------------------------------------------------------------------
// poc_crc8
// CRC-8 (init 0xFF, poly 0xD5) over a five-byte message, top byte first.
// ----------------------------------------------------------------------------
module poc_crc8 import poc_pkg::*; (
	input  logic [CRC_MSG_W-1:0] msg,
	output logic [7:0]           crc
);

	always_comb begin
		logic [7:0] c;
		c = CRC_INIT;
		for (int i = CRC_BYTES - 1; i >= 0; i--) begin
			c = crc8_byte(c, msg[8*i +: 8]);
		end
		crc = c;
	end

endmodule

// ===== sv/pedal_override_controller_top.sv =====
// ----------------------------------------------------------------------------
// pedal_override_controller_top
// Gas pedal override: command frame check, status frames, pedal drive.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | word
//  evt     | in  | valid/ready       | operation, frame id/payload, samples
//  res     | out | valid/ready       | drives, status frame, led, fault, reboot
//  cfg     | in  | cfg_wr_en         | cfg_index, cfg_wdata (16 bits)
//
// One event per cycle sustained while res is ready.
// An input register feeds one pass of logic (two 40-bit CRC-8 trees, setpoint
// compare) into the result register, where the state updates too.
// res stalls hold the result register; evt stays ready while the input stage
// can drain into it. arst_n clears state and counters, config takes defaults.
// ----------------------------------------------------------------------------
`include "pedal_override_controller_top_macros.svh"

module pedal_override_controller_top import poc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	poc_evt_if.sink     evt,
	poc_res_if.source   res
);

	// configuration
	logic [10:0] input_id_q;
	logic [10:0] output_id_q;
	logic [15:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_id_q  <= INPUT_ID_RST;
			output_id_q <= OUTPUT_ID_RST;
			timeout_q   <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_INPUT_ID:  input_id_q  <= cfg_wdata[10:0];
				CFG_OUTPUT_ID: output_id_q <= cfg_wdata[10:0];
				CFG_TIMEOUT:   timeout_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// status frame id is held for the transmit side; it feeds no result field
	logic out_id_unused;
	assign out_id_unused = ^output_id_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [10:0] fid_s1;
	logic [31:0] lo_s1;
	logic [31:0] hi_s1;
	logic        mfree_s1;
	logic [11:0] sa_s1;
	logic [11:0] sb_s1;

	logic    out_valid_q;
	result_t res_q;
	logic    advance;

	assign advance   = valid_s1 && (!out_valid_q || res.ready);
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			op_s1    <= evt.operation;
			fid_s1   <= evt.frame_id;
			lo_s1    <= evt.frame_low_word;
			hi_s1    <= evt.frame_high_word;
			mfree_s1 <= evt.mailbox_free;
			sa_s1    <= evt.sample_a;
			sb_s1    <= evt.sample_b;
		end
	end

	// state
	logic [2:0]  fault_q;
	logic [15:0] sp_a_q, sp_b_q;
	logic [15:0] idle_q;
	cnt_t        rx_cnt_q, tx_cnt_q;
	logic [11:0] last_sa_q, last_sb_q;
	logic        led_q;

	logic [2:0]  fault_n;
	logic [15:0] sp_a_n, sp_b_n;
	logic [15:0] idle_n;
	cnt_t        rx_cnt_n, tx_cnt_n;
	logic [11:0] last_sa_n, last_sb_n;
	logic        led_n;
	result_t     res_n;

	// CRC over received bytes 4..0 and over the outgoing status bytes 4..0
	logic [7:0]           rx_crc, tx_crc;
	logic [7:0]           tx_b4;
	logic [CRC_MSG_W-1:0] rx_msg, tx_msg;

	assign tx_b4  = {1'b0, fault_q, 4'(tx_cnt_q)};
	assign rx_msg = {hi_s1[7:0], lo_s1};
	// status byte 0 is sample_a high, byte 3 sample_b low
	assign tx_msg = {tx_b4, last_sb_q[7:0], 4'h0, last_sb_q[11:8],
	                 last_sa_q[7:0], 4'h0, last_sa_q[11:8]};

	poc_crc8 u_rx_crc (.msg(rx_msg), .crc(rx_crc));
	poc_crc8 u_tx_crc (.msg(tx_msg), .crc(tx_crc));

	logic        rx_reboot;
	logic [15:0] v0, v1;
	cnt_t        rx_idx;

	assign v0     = {lo_s1[7:0], lo_s1[15:8]};
	assign v1     = {lo_s1[23:16], lo_s1[31:24]};
	assign rx_idx = hi_s1[CNT_BITS-1:0];
	assign rx_reboot = (op_s1 == OP_FRAME) && (fid_s1 == input_id_q)
	                   && (lo_s1 == REBOOT_KEY_LO)
	                   && ((hi_s1 == REBOOT_SOFT_HI) || (hi_s1 == REBOOT_BOOT_HI));

	always_comb begin
		fault_n   = fault_q;
		sp_a_n    = sp_a_q;
		sp_b_n    = sp_b_q;
		idle_n    = idle_q;
		rx_cnt_n  = rx_cnt_q;
		tx_cnt_n  = tx_cnt_q;
		last_sa_n = last_sa_q;
		last_sb_n = last_sb_q;
		led_n     = led_q;
		res_n     = '0;

		case (op_s1)
			OP_FRAME: begin
				if (fid_s1 == input_id_q) begin
					if (rx_reboot) begin
						res_n.reboot_request = (hi_s1 == REBOOT_SOFT_HI) ? RBT_SOFT : RBT_BOOT;
						fault_n   = FLT_NONE;
						sp_a_n    = '0;
						sp_b_n    = '0;
						idle_n    = '0;
						rx_cnt_n  = '0;
						tx_cnt_n  = '0;
						last_sa_n = '0;
						last_sb_n = '0;
						led_n     = 1'b0;
					end else if (rx_crc == hi_s1[15:8]) begin
						if (cnt_t'(rx_cnt_q + 1'b1) == rx_idx) begin
							if (hi_s1[7]) begin
								sp_a_n = v0;
								sp_b_n = v1;
							end else begin
								fault_n = ((v0 == '0) && (v1 == '0)) ? FLT_NONE : FLT_INVALID;
								sp_a_n  = '0;
								sp_b_n  = '0;
							end
							idle_n = '0;
						end
						rx_cnt_n = rx_idx;
					end else begin
						fault_n = FLT_BAD_CRC;
					end
				end
			end
			OP_TICK: begin
				if (mfree_s1) begin
					res_n.tx_valid     = 1'b1;
					res_n.tx_low_word  = tx_msg[31:0];
					res_n.tx_high_word = {tx_crc, tx_b4};
					tx_cnt_n           = cnt_t'(tx_cnt_q + 1'b1);
				end else begin
					fault_n = FLT_SEND;
				end
				res_n.led_on = led_q;
				led_n        = ~led_q;
				if (idle_q == timeout_q) begin
					fault_n = FLT_TIMEOUT;
				end else begin
					idle_n = idle_q + 16'd1;
				end
			end
			OP_PEDAL: begin
				last_sa_n = sa_s1;
				last_sb_n = sb_s1;
				if (fault_q == FLT_NONE) begin
					res_n.drive_a = (sp_a_q > {4'h0, sa_s1}) ? sp_a_q : {4'h0, sa_s1};
					res_n.drive_b = (sp_b_q > {4'h0, sb_s1}) ? sp_b_q : {4'h0, sb_s1};
				end else begin
					res_n.drive_a = {4'h0, sa_s1};
					res_n.drive_b = {4'h0, sb_s1};
				end
			end
			default: begin
				fault_n = FLT_BUS_ERR;
			end
		endcase

		res_n.fault_code = fault_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q   <= FLT_NONE;
			sp_a_q    <= '0;
			sp_b_q    <= '0;
			idle_q    <= '0;
			rx_cnt_q  <= '0;
			tx_cnt_q  <= '0;
			last_sa_q <= '0;
			last_sb_q <= '0;
			led_q     <= 1'b0;
		end else if (advance) begin
			fault_q   <= fault_n;
			sp_a_q    <= sp_a_n;
			sp_b_q    <= sp_b_n;
			idle_q    <= idle_n;
			rx_cnt_q  <= rx_cnt_n;
			tx_cnt_q  <= tx_cnt_n;
			last_sa_q <= last_sa_n;
			last_sb_q <= last_sb_n;
			led_q     <= led_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.drive_a        = res_q.drive_a;
	assign res.drive_b        = res_q.drive_b;
	assign res.tx_valid       = res_q.tx_valid;
	assign res.tx_low_word    = res_q.tx_low_word;
	assign res.tx_high_word   = res_q.tx_high_word;
	assign res.led_on         = res_q.led_on;
	assign res.fault_code     = res_q.fault_code;
	assign res.reboot_request = res_q.reboot_request;

	`POC_ASSERT(a_stall_only_when_full,
		!evt.ready |-> (valid_s1 && out_valid_q && !res.ready),
		"evt stalled without a full pipe")
	`POC_ASSERT(a_advance_fills_out, advance |=> out_valid_q, "result register lost an item")
	`POC_ASSERT(a_reboot_clears,
		(advance && rx_reboot) |=> (fault_q == FLT_NONE && sp_a_q == '0 && sp_b_q == '0
			&& idle_q == '0 && led_q == 1'b0),
		"reboot left state behind")
	`POC_ASSERT(a_tx_only_on_tick,
		(res.valid && res.tx_valid) |-> (res.drive_a == '0 && res.drive_b == '0
			&& res.reboot_request == RBT_NONE),
		"status frame mixed with other event results")
	`POC_ASSERT_ALWAYS(a_fault_range, (!arst_n || fault_q <= FLT_TIMEOUT), "fault code out of range")

endmodule
